// ----- hdl/pce_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pce_pkg
// Shared types and constants for the Pearson correlation engine.
// ----------------------------------------------------------------------------
package pce_pkg;

  // Largest number of pairs that one series may hold.
  localparam int unsigned MaxPairs = 65536;
  localparam int unsigned CntW     = 17;

  // Status codes of a result.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_VAR = 2'd1,
    STAT_TOO_MANY = 2'd2
  } pce_status_e;

  // One input beat.
  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic               last_pair;
  } pce_in_t;

  // One result beat.
  typedef struct packed {
    logic signed [15:0] coefficient;
    pce_status_e        status;
  } pce_out_t;

  // Accumulator snapshot handed from the front to the back.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [32:0]     sum_a;
    logic [32:0]     sum_b;
    logic [46:0]     sum_aa;
    logic [46:0]     sum_bb;
    logic [47:0]     sum_ab;
    logic            ovf;
  } pce_snap_t;

  // Queue status seen by the top level and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } pce_qstat_t;

  // Back-end state machine.
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_ISSUE,
    BS_RUN,
    BS_POST,
    BS_EMIT
  } pce_bstate_e;

  // Multiplications run by the back end.
  typedef enum logic [3:0] {
    OP_NAA,
    OP_SA2,
    OP_NBB,
    OP_SB2,
    OP_NAB,
    OP_SASB,
    OP_PP,
    OP_CC,
    OP_TT,
    OP_TP
  } pce_op_e;

endpackage
`default_nettype wire

// ----- hdl/pce_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pce_front
// Accumulates sample pairs and hands a snapshot to the queue on the last pair.
// ----------------------------------------------------------------------------
module pce_front
  import pce_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire pce_in_t    in_i,
  output logic            push_o,
  output pce_snap_t       snap_o
);

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [32:0]        sa_q, sa_d, sb_q, sb_d;
  logic [46:0]        saa_q, saa_d, sbb_q, sbb_d;
  logic [47:0]        sab_q, sab_d;
  logic               ovf_q, ovf_d;
  logic signed [31:0] aa, bb, ab;
  logic               at_max;

  // Products of the incoming pair.
  always_comb begin
    aa = in_i.sample_a * in_i.sample_a;
    bb = in_i.sample_b * in_i.sample_b;
    ab = in_i.sample_a * in_i.sample_b;
  end

  assign at_max = (cnt_q == CntW'(MaxPairs));

  // Next accumulator values; pairs past the limit only set the flag.
  always_comb begin
    cnt_d = cnt_q;
    sa_d  = sa_q;
    sb_d  = sb_q;
    saa_d = saa_q;
    sbb_d = sbb_q;
    sab_d = sab_q;
    ovf_d = ovf_q;
    if (at_max) begin
      ovf_d = 1'b1;
    end else begin
      cnt_d = cnt_q + CntW'(1);
      sa_d  = sa_q + {{17{in_i.sample_a[15]}}, in_i.sample_a};
      sb_d  = sb_q + {{17{in_i.sample_b[15]}}, in_i.sample_b};
      saa_d = saa_q + {15'd0, aa};
      sbb_d = sbb_q + {15'd0, bb};
      sab_d = sab_q + {{16{ab[31]}}, ab};
    end
  end

  assign push_o = accept_i && in_i.last_pair;

  always_comb begin
    snap_o.cnt    = cnt_d;
    snap_o.sum_a  = sa_d;
    snap_o.sum_b  = sb_d;
    snap_o.sum_aa = saa_d;
    snap_o.sum_bb = sbb_d;
    snap_o.sum_ab = sab_d;
    snap_o.ovf    = ovf_d;
  end

  // Accumulator registers, cleared after the last pair of a series.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sa_q  <= '0;
      sb_q  <= '0;
      saa_q <= '0;
      sbb_q <= '0;
      sab_q <= '0;
      ovf_q <= 1'b0;
    end else if (accept_i) begin
      if (in_i.last_pair) begin
        cnt_q <= '0;
        sa_q  <= '0;
        sb_q  <= '0;
        saa_q <= '0;
        sbb_q <= '0;
        sab_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        sa_q  <= sa_d;
        sb_q  <= sb_d;
        saa_q <= saa_d;
        sbb_q <= sbb_d;
        sab_q <= sab_d;
        ovf_q <= ovf_d;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pce_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pce_queue
// Two-entry queue of accumulator snapshots between front and back.
// ----------------------------------------------------------------------------
module pce_queue
  import pce_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire pce_snap_t snap_i,
  input  wire logic      pop_i,
  output pce_snap_t      head_o,
  output pce_qstat_t     stat_o
);

  pce_snap_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign head_o       = mem_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= snap_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pce_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pce_back
// Computes the coefficient from a snapshot with a shared shift-add
// multiplier and a bitwise search for the quotient of the square root.
// ----------------------------------------------------------------------------
module pce_back
  import pce_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pce_snap_t  head_i,
  input  wire pce_qstat_t qstat_i,
  output logic            pop_o,
  output logic            result_valid_o,
  output pce_out_t        result_o
);

  pce_bstate_e        state_q, state_d;
  pce_op_e            op_q, op_d;
  pce_snap_t          snap_q;
  logic [159:0]       mx_q, acc_q;
  logic [63:0]        my_q;
  logic [63:0]        t1_q, dx_q, dy_q, p1_q, c_q;
  logic               neg_q;
  logic [127:0]       pp_q;
  logic [159:0]       rr_q;
  logic [31:0]        tsq_q;
  logic [15:0]        k_q;
  logic [3:0]         bit_q;
  logic signed [15:0] coef_q;
  pce_status_e        stat_q;

  logic [32:0]  mag_a, mag_b;
  logic [47:0]  mag_ab;
  logic [127:0] op_x;
  logic [63:0]  op_y;
  logic [15:0]  cand, k_new;
  logic [16:0]  tval;
  logic         trial_ok, search_end, zero_var;
  logic         s1, s2;
  logic [63:0]  p2;

  // Magnitudes of the signed sums.
  always_comb begin
    mag_a  = snap_q.sum_a[32] ? (33'd0 - snap_q.sum_a) : snap_q.sum_a;
    mag_b  = snap_q.sum_b[32] ? (33'd0 - snap_q.sum_b) : snap_q.sum_b;
    mag_ab = snap_q.sum_ab[47] ? (48'd0 - snap_q.sum_ab) : snap_q.sum_ab;
  end

  // Search candidate and its odd multiplier 2k-1.
  always_comb begin
    cand       = k_q | (16'd1 << bit_q);
    tval       = {cand, 1'b0} - 17'd1;
    trial_ok   = (acc_q <= rr_q);
    k_new      = trial_ok ? cand : k_q;
    search_end = (bit_q == 4'd0) || (k_new == 16'h8000);
    zero_var   = (dx_q == 64'd0) || (dy_q == 64'd0);
    p2         = acc_q[63:0];
    s1         = snap_q.sum_ab[47];
    s2         = snap_q.sum_a[32] ^ snap_q.sum_b[32];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_x = '0;
    op_y = '0;
    unique case (op_q)
      OP_NAA:  begin op_x = 128'(snap_q.sum_aa); op_y = 64'(snap_q.cnt); end
      OP_SA2:  begin op_x = 128'(mag_a);         op_y = 64'(mag_a);      end
      OP_NBB:  begin op_x = 128'(snap_q.sum_bb); op_y = 64'(snap_q.cnt); end
      OP_SB2:  begin op_x = 128'(mag_b);         op_y = 64'(mag_b);      end
      OP_NAB:  begin op_x = 128'(mag_ab);        op_y = 64'(snap_q.cnt); end
      OP_SASB: begin op_x = 128'(mag_a);         op_y = 64'(mag_b);      end
      OP_PP:   begin op_x = 128'(dx_q);          op_y = dy_q;            end
      OP_CC:   begin op_x = 128'(c_q);           op_y = c_q;             end
      OP_TT:   begin op_x = 128'(tval);          op_y = 64'(tval);       end
      OP_TP:   begin op_x = pp_q;                op_y = 64'(tsq_q);      end
      default: begin op_x = '0;                  op_y = '0;              end
    endcase
  end

  // Next state and sequencing.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    pop_o   = 1'b0;
    unique case (state_q)
      BS_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          op_d    = OP_NAA;
          state_d = head_i.ovf ? BS_EMIT : BS_ISSUE;
        end
      end
      BS_ISSUE: begin
        state_d = BS_RUN;
      end
      BS_RUN: begin
        if (my_q == 64'd0) begin
          state_d = BS_POST;
        end
      end
      BS_POST: begin
        state_d = BS_ISSUE;
        unique case (op_q)
          OP_NAA:  op_d = OP_SA2;
          OP_SA2:  op_d = OP_NBB;
          OP_NBB:  op_d = OP_SB2;
          OP_SB2:  op_d = OP_NAB;
          OP_NAB:  op_d = OP_SASB;
          OP_SASB: begin
            op_d = OP_PP;
            if (zero_var) begin
              state_d = BS_EMIT;
            end
          end
          OP_PP:   op_d = OP_CC;
          OP_CC:   op_d = OP_TT;
          OP_TT:   op_d = OP_TP;
          OP_TP:   begin
            op_d = OP_TT;
            if (search_end) begin
              state_d = BS_EMIT;
            end
          end
          default: op_d = OP_NAA;
        endcase
      end
      BS_EMIT: begin
        state_d = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      op_q    <= OP_NAA;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Datapath: multiplier steps and the handling of each finished product.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BS_IDLE: begin
        snap_q <= head_i;
        coef_q <= '0;
        stat_q <= STAT_TOO_MANY;
      end
      BS_ISSUE: begin
        mx_q  <= 160'(op_x);
        my_q  <= op_y;
        acc_q <= '0;
      end
      BS_RUN: begin
        if (my_q[0]) begin
          acc_q <= acc_q + mx_q;
        end
        mx_q <= mx_q << 1;
        my_q <= my_q >> 1;
      end
      BS_POST: begin
        unique case (op_q)
          OP_NAA:  t1_q <= acc_q[63:0];
          OP_SA2:  dx_q <= t1_q - acc_q[63:0];
          OP_NBB:  t1_q <= acc_q[63:0];
          OP_SB2:  dy_q <= t1_q - acc_q[63:0];
          OP_NAB:  p1_q <= acc_q[63:0];
          OP_SASB: begin
            if (s1 == s2) begin
              if (p1_q >= p2) begin
                c_q   <= p1_q - p2;
                neg_q <= s1;
              end else begin
                c_q   <= p2 - p1_q;
                neg_q <= !s1;
              end
            end else begin
              c_q   <= p1_q + p2;
              neg_q <= s1;
            end
            coef_q <= '0;
            stat_q <= zero_var ? STAT_ZERO_VAR : STAT_OK;
          end
          OP_PP:   pp_q <= acc_q[127:0];
          OP_CC:   begin
            rr_q  <= acc_q << 32;
            k_q   <= '0;
            bit_q <= 4'd15;
          end
          OP_TT:   tsq_q <= acc_q[31:0];
          OP_TP:   begin
            k_q   <= k_new;
            bit_q <= bit_q - 4'd1;
            if (neg_q) begin
              coef_q <= 16'(16'd0 - k_new);
            end else if (k_new == 16'h8000) begin
              coef_q <= 16'sh7fff;
            end else begin
              coef_q <= k_new;
            end
          end
          default: t1_q <= t1_q;
        endcase
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign result_valid_o       = (state_q == BS_EMIT);
  assign result_o.coefficient = coef_q;
  assign result_o.status      = stat_q;

  // A result beat lasts one cycle and the back returns to idle.
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result beat longer than one cycle");

  // A too-many or zero-variance result carries a zero coefficient.
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (stat_q == STAT_TOO_MANY || stat_q == STAT_ZERO_VAR))
      |-> (coef_q == 16'sd0))
    else $error("flagged result with nonzero coefficient");

  // The multiplier consumes one multiplier bit per running cycle.
  a_mul_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_RUN && my_q != 64'd0) |=> (my_q == ($past(my_q) >> 1)))
    else $error("multiplier did not advance");

  // The back takes a snapshot only from a nonempty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !qstat_i.empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- hdl/pearson_correlation_engine_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pearson_correlation_engine_top
// Pearson correlation of two sample series with saturated Q1.15 output.
// ----------------------------------------------------------------------------
// Each pair is accumulated as it is accepted; pairs may follow back to back
// while busy is low. With the back free, an overlong series passes the queue
// and goes from idle straight to its result, and a full computation runs the
// shift-add multiplier over each product, one multiplier bit a cycle.
// Two closed series can wait in the queue; busy is high while it is full.
// Reset clears the accumulators, the queue and the sequencer at once.
module pearson_correlation_engine_top
  import pce_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  input  wire pce_in_t in_i,
  output logic         result_valid_o,
  output pce_out_t     result_o
);

  logic       accept, push, pop;
  pce_snap_t  snap, head;
  pce_qstat_t qstat;

  assign busy   = qstat.full;
  assign accept = start && !busy;

  pce_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .push_o   (push),
    .snap_o   (snap)
  );

  pce_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .snap_i (snap),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  pce_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .qstat_i        (qstat),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Pearson correlation engine top level.
// ----------------------------------------------------------------------------
// Sample pairs are driven as command beats, with random idle bursts on the
// sending side. An exact integer predictor keeps its own accumulators and
// works out each closing result with wide bit vectors. Every result beat is
// compared field by field against the oldest expected one. A short directed
// table comes first, then random series with random content.
module testbench
  import pce_pkg::*;
();

  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int unsigned DrainCycles  = 1500;
  localparam int unsigned RandomPairs  = 880;
  localparam int unsigned QuietTail    = 100;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  pce_in_t  in_i   = '0;
  logic     busy;
  logic     result_valid_o;
  pce_out_t result_o;

  pearson_correlation_engine_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Clock with a period of two time units.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state: the running series.
  int unsigned pair_cnt;
  longint      acc_a, acc_b, acc_aa, acc_bb, acc_ab;
  bit          acc_ovf;

  pce_out_t    corr_expected[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_en = 1'b1;
  int unsigned pairs_sent = 0;

  // Directed stimulus row; a typed row carries its own expected result.
  typedef struct {
    logic [15:0] a;
    logic [15:0] b;
    bit          last;
    bit          typed;
    logic [15:0] coef;
    pce_status_e st;
  } pair_row_t;

  pair_row_t directed[] = '{
    '{16'sd5,     16'sd7,     1'b1, 1'b1, 16'sd0,     STAT_ZERO_VAR},
    '{16'h7FFF,   16'h7FFF,   1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'h8000,   16'h8000,   1'b1, 1'b1, 16'h7FFF,   STAT_OK},
    '{16'h7FFF,   16'h8000,   1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'h8000,   16'h7FFF,   1'b1, 1'b1, 16'h8000,   STAT_OK},
    '{16'sd100,   16'sd1,     1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'sd100,   16'sd2,     1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'sd100,   16'sd3,     1'b1, 1'b1, 16'sd0,     STAT_ZERO_VAR},
    '{16'sd1,     16'sd0,     1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'sd2,     16'sd0,     1'b1, 1'b1, 16'sd0,     STAT_ZERO_VAR},
    '{16'sd0,     16'sd0,     1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'sd1,     16'sd2,     1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'sd2,     16'sd1,     1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'hFFFF,   16'sd3,     1'b1, 1'b0, 16'sd0,     STAT_OK},
    '{16'hAAAA,   16'h5555,   1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'h5555,   16'hAAAA,   1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'h1234,   16'h4321,   1'b1, 1'b0, 16'sd0,     STAT_OK},
    '{16'h8000,   16'sd0,     1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'sd0,     16'h7FFF,   1'b0, 1'b0, 16'sd0,     STAT_OK},
    '{16'h7FFF,   16'hFFFF,   1'b1, 1'b0, 16'sd0,     STAT_OK}
  };

  function automatic void clear_series();
    pair_cnt = 0;
    acc_a    = 0;
    acc_b    = 0;
    acc_aa   = 0;
    acc_bb   = 0;
    acc_ab   = 0;
    acc_ovf  = 1'b0;
  endfunction

  // Accumulate one pair; on the closing pair return the exact Q1.15 result.
  function automatic pce_out_t corr_update(input logic signed [15:0] a,
                                           input logic signed [15:0] b,
                                           input bit last, output bit closed);
    logic signed [255:0] sn, sa, sb, saa, sbb, sab;
    logic signed [255:0] dx, dy, cov, c, prod, rhs, t;
    int unsigned lo, hi, mid;
    pce_out_t r;
    closed = 1'b0;
    r = '0;
    if (pair_cnt >= MaxPairs) begin
      acc_ovf = 1'b1;
    end else begin
      pair_cnt++;
      acc_a  += a;
      acc_b  += b;
      acc_aa += longint'(a) * longint'(a);
      acc_bb += longint'(b) * longint'(b);
      acc_ab += longint'(a) * longint'(b);
    end
    if (!last) return r;
    closed = 1'b1;
    if (acc_ovf) begin
      r.status = STAT_TOO_MANY;
    end else begin
      sn  = pair_cnt;
      sa  = acc_a;
      sb  = acc_b;
      saa = acc_aa;
      sbb = acc_bb;
      sab = acc_ab;
      dx  = sn * saa - sa * sa;
      dy  = sn * sbb - sb * sb;
      if (dx == 0 || dy == 0) begin
        r.status = STAT_ZERO_VAR;
      end else begin
        cov  = sn * sab - sa * sb;
        c    = (cov < 0) ? -cov : cov;
        prod = dx * dy;
        rhs  = (c * c) <<< 32;
        // Largest k with (2k-1)^2 * dx*dy <= 2^32 * c^2 gives rounding
        // to nearest with ties away from zero.
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          t   = 2 * mid - 1;
          if (t * t * prod <= rhs) lo = mid;
          else hi = mid - 1;
        end
        if (cov < 0) r.coefficient = 16'(0 - lo);
        else r.coefficient = 16'((lo > 32767) ? 32767 : lo);
        r.status = STAT_OK;
      end
    end
    clear_series();
    return r;
  endfunction

  // Drive one pair beat and hold it until the engine accepts it.
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b,
                           input bit last, input bit typed,
                           input pce_out_t typed_res);
    pce_out_t r;
    bit closed;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_i.sample_a  = a;
    in_i.sample_b  = b;
    in_i.last_pair = last;
    start          = 1'b1;
    do @(posedge clk_i); while (busy);
    r = corr_update(a, b, last, closed);
    if (closed) corr_expected = {corr_expected, (typed ? typed_res : r)};
    pairs_sent++;
  endtask

  // Random sample drawn according to the series flavor.
  function automatic logic [15:0] pick_sample(input int unsigned flavor);
    logic [15:0] extremes[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    case (flavor)
      0: return 16'($urandom);
      1: return extremes[$urandom_range(0, 3)];
      default: return 16'($urandom_range(0, 15) - 8);
    endcase
  endfunction

  // Result checker: compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    pce_out_t want;
    if (rst_ni && result_valid_o) begin
      if (corr_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: coefficient %0d status %0d",
                   $signed(result_o.coefficient), result_o.status);
      end else begin
        want = corr_expected.pop_front();
        if (result_o.coefficient !== want.coefficient ||
            result_o.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected coefficient %0d status %0d, got %0d status %0d",
                     $signed(want.coefficient), want.status,
                     $signed(result_o.coefficient), result_o.status);
        end
      end
    end
  end

  // Watchdog on the total cycle count.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    pce_out_t typed_res;
    int unsigned len, flavor;
    logic [15:0] a, b;
    clear_series();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table.
    foreach (directed[i]) begin
      typed_res.coefficient = directed[i].coef;
      typed_res.status      = directed[i].st;
      send_pair(directed[i].a, directed[i].b, directed[i].last,
                directed[i].typed, typed_res);
    end

    // Random series, mostly short; some of one pair, some correlated.
    pairs_sent = 0;
    while (pairs_sent < RandomPairs) begin
      len    = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
      flavor = $urandom_range(0, 3);
      for (int unsigned i = 0; i < len; i++) begin
        idle_en = (pairs_sent < RandomPairs - QuietTail);
        a = pick_sample(flavor == 3 ? 0 : flavor);
        if (flavor == 3)
          b = $urandom_range(0, 1) ? 16'(a + ($urandom_range(0, 63) - 32)) : -a;
        else
          b = pick_sample(flavor);
        send_pair(a, b, i == len - 1, 1'b0, '0);
      end
    end
    @(negedge clk_i);
    start = 1'b0;

    // Drain outstanding results, then allow for late extras.
    while (corr_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
